@@ src/lattice_predator_prey_event_unit_macros.svh @@
// Assertion macros for the lattice predator-prey event unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LATTICE_PREDATOR_PREY_EVENT_UNIT_MACROS_SVH
`define LATTICE_PREDATOR_PREY_EVENT_UNIT_MACROS_SVH

// cond must hold at every edge out of reset
`define LPPE_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold at the same edge as ante
`define LPPE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/lppe_pkg.sv @@
// Shared types and constants of the lattice predator-prey event unit.
// No dependencies.
`timescale 1ns / 1ps

package lppe_pkg;

	// widest lattice coordinate over the supported lattice sizes (up to 1024)
	localparam int CoordW = 10;

	localparam logic [3:0] OC_PLACED        = 4'd0;
	localparam logic [3:0] OC_PLACE_FULL    = 4'd1;
	localparam logic [3:0] OC_PRED_MOVED    = 4'd2;
	localparam logic [3:0] OC_PRED_BLOCKED  = 4'd3;
	localparam logic [3:0] OC_ATE           = 4'd4;
	localparam logic [3:0] OC_NO_PREY       = 4'd5;
	localparam logic [3:0] OC_DIED          = 4'd6;
	localparam logic [3:0] OC_PREY_MOVED    = 4'd7;
	localparam logic [3:0] OC_PREY_BLOCKED  = 4'd8;
	localparam logic [3:0] OC_BORN          = 4'd9;
	localparam logic [3:0] OC_BIRTH_BLOCKED = 4'd10;
	localparam logic [3:0] OC_EMPTY         = 4'd11;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_EVENT = 1'b1;

	localparam logic SPC_PREDATOR = 1'b0;
	localparam logic SPC_PREY     = 1'b1;

	localparam logic [1:0] REG_PRED_MOVE = 2'd0;
	localparam logic [1:0] REG_PRED_EAT  = 2'd1;
	localparam logic [1:0] REG_PREY_MOVE = 2'd2;
	localparam logic [1:0] REG_CAPACITY  = 2'd3;

	typedef struct packed {
		logic        command;
		logic        species;
		logic [7:0]  row;
		logic [7:0]  column;
		logic [18:0] particle_rank;
		logic [15:0] action_roll;
		logic [15:0] neighbor_roll;
	} lppe_in_t;

	typedef struct packed {
		logic [3:0]  outcome;
		logic [7:0]  target_row;
		logic [7:0]  target_column;
		logic [18:0] predator_population;
		logic [18:0] prey_population;
	} lppe_out_t;

	// command after coordinate reduction, as queued for the back end
	typedef struct packed {
		logic              command;
		logic              species;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [18:0]       rank;
		logic [15:0]       act;
		logic [15:0]       nroll;
	} lppe_cmd_t;

	typedef struct packed {
		logic [15:0] pred_move_threshold;
		logic [15:0] pred_eat_threshold;
		logic [15:0] prey_move_threshold;
		logic [2:0]  max_occupancy;
	} lppe_cfg_t;

endpackage

@@ src/lattice_predator_prey_event_unit.sv @@
// Lattice predator-prey event unit: a place or event command goes in, one outcome comes
// out. In the back end a place command reads its site, checks it, writes it back if it
// has room and presents the item; an event searches row by row up to the row that holds
// the ranked particle, then site by site along that row, then reads the four neighbors,
// decides, writes back and presents the item.
// The rank search goes through the single read port of the row-sum memory and then of
// the site memory. The front end folds coordinates onto the lattice and queues two
// commands ahead. After reset a clearing pass writes zero through the site memory;
// commands wait in the queue until it ends, while register writes are taken at once.
`timescale 1ns / 1ps

`include "lattice_predator_prey_event_unit_macros.svh"

module lattice_predator_prey_event_unit import lppe_pkg::*; #(
	parameter int GRID_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  lppe_in_t    cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output lppe_out_t   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lppe_cfg_t cfg_q;
	logic      q_push, q_pop, q_full, q_empty;
	lppe_cmd_t q_in, q_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pred_move_threshold <= 16'd26214;
			cfg_q.pred_eat_threshold  <= 16'd48059;
			cfg_q.prey_move_threshold <= 16'd21845;
			cfg_q.max_occupancy       <= 3'd5;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_PRED_MOVE: cfg_q.pred_move_threshold <= pwdata[15:0];
				REG_PRED_EAT:  cfg_q.pred_eat_threshold  <= pwdata[15:0];
				REG_PREY_MOVE: cfg_q.prey_move_threshold <= pwdata[15:0];
				REG_CAPACITY:  cfg_q.max_occupancy       <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PRED_MOVE: prdata = {16'd0, cfg_q.pred_move_threshold};
			REG_PRED_EAT:  prdata = {16'd0, cfg_q.pred_eat_threshold};
			REG_PREY_MOVE: prdata = {16'd0, cfg_q.prey_move_threshold};
			REG_CAPACITY:  prdata = {29'd0, cfg_q.max_occupancy};
		endcase
	end

	lppe_front #(.GRID_SIDE(GRID_SIDE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.push     (q_push),
		.q_full   (q_full),
		.push_data(q_in)
	);

	lppe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.pop_data (q_out),
		.full     (q_full),
		.empty    (q_empty)
	);

	lppe_back #(.GRID_SIDE(GRID_SIDE)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (q_out),
		.pop      (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	`LPPE_ASSERT_IMPLY(a_no_push_full, q_push, !q_full, "push into a full queue")
	`LPPE_ASSERT_IMPLY(a_no_pop_empty, q_pop, !q_empty, "pop from an empty queue")
	`LPPE_ASSERT_IMPLY(a_empty_origin, res_valid && res.outcome == OC_EMPTY, res.target_row == 8'd0 && res.target_column == 8'd0, "empty outcome off origin")

endmodule

@@ src/lppe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lppe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/lppe_front.sv @@
// Front end: accepts command items and folds coordinates onto the lattice.
// Depends on lppe_pkg.
`timescale 1ns / 1ps

module lppe_front import lppe_pkg::*; #(
	parameter int GRID_SIDE = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  lppe_in_t  cmd,
	output logic      push,
	input  logic      q_full,
	output lppe_cmd_t push_data
);

	localparam int RedW = CoordW + 1;
	localparam logic [RedW-1:0] Side = RedW'(GRID_SIDE);

	logic            busy_q;
	logic [RedW-1:0] rx_q, ry_q;
	lppe_cmd_t       hold_q;
	logic            done;

	assign cmd_stall = busy_q;
	assign done = (rx_q < Side) && (ry_q < Side);
	assign push = busy_q && done && !q_full;

	always_comb begin
		push_data = hold_q;
		push_data.x = rx_q[CoordW-1:0];
		push_data.y = ry_q[CoordW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd_valid && !busy_q) begin
			busy_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	// one subtract per coordinate per cycle until both coordinates lie on the lattice
	always_ff @(posedge clk) begin
		if (cmd_valid && !busy_q) begin
			hold_q.command <= cmd.command;
			hold_q.species <= cmd.species;
			hold_q.x       <= '0;
			hold_q.y       <= '0;
			hold_q.rank    <= cmd.particle_rank;
			hold_q.act     <= cmd.action_roll;
			hold_q.nroll   <= cmd.neighbor_roll;
			rx_q <= RedW'(cmd.row);
			ry_q <= RedW'(cmd.column);
		end else if (busy_q) begin
			if (rx_q >= Side) begin
				rx_q <= rx_q - Side;
			end
			if (ry_q >= Side) begin
				ry_q <= ry_q - Side;
			end
		end
	end

endmodule

@@ src/lppe_queue.sv @@
// Two-entry queue between the front end and the back end.
// Depends on lppe_pkg.
`timescale 1ns / 1ps

module lppe_queue import lppe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lppe_cmd_t push_data,
	input  logic      pop,
	output lppe_cmd_t pop_data,
	output logic      full,
	output logic      empty
);

	lppe_cmd_t  ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign pop_data = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

@@ src/lppe_back.sv @@
// Back end: lattice memories, rank search, event decision and site updates.
// Depends on lppe_pkg and lppe_ram.
`timescale 1ns / 1ps

module lppe_back import lppe_pkg::*; #(
	parameter int GRID_SIDE = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lppe_cfg_t cfg,
	input  logic      q_empty,
	input  lppe_cmd_t q_data,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_stall,
	output lppe_out_t res
);

	localparam int XW    = $clog2(GRID_SIDE);
	localparam int Cells = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(Cells);
	localparam int RsW   = XW + 4;
	localparam int AccW  = AW + 4;
	localparam logic [XW-1:0] XMax = XW'(GRID_SIDE - 1);
	localparam logic [AW-1:0] CellLast = AW'(Cells - 1);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_PL_RD  = 4'd2;
	localparam logic [3:0] S_PL_CK  = 4'd3;
	localparam logic [3:0] S_ROW_RD = 4'd4;
	localparam logic [3:0] S_ROW_CK = 4'd5;
	localparam logic [3:0] S_COL_RD = 4'd6;
	localparam logic [3:0] S_COL_CK = 4'd7;
	localparam logic [3:0] S_NB_RD  = 4'd8;
	localparam logic [3:0] S_NB_CK  = 4'd9;
	localparam logic [3:0] S_DEC    = 4'd10;
	localparam logic [3:0] S_OP_RD  = 4'd11;
	localparam logic [3:0] S_OP_WR  = 4'd12;
	localparam logic [3:0] S_FIN    = 4'd13;

	localparam logic [2:0] M_PMOVE = 3'd0;
	localparam logic [2:0] M_EAT   = 3'd1;
	localparam logic [2:0] M_DIE   = 3'd2;
	localparam logic [2:0] M_YMOVE = 3'd3;
	localparam logic [2:0] M_BIRTH = 3'd4;

	// site codes: own site, then right, left, up, down
	localparam logic [2:0] SC_OWN   = 3'd0;
	localparam logic [2:0] SC_RIGHT = 3'd1;
	localparam logic [2:0] SC_LEFT  = 3'd2;
	localparam logic [2:0] SC_UP    = 3'd3;
	localparam logic [2:0] SC_DOWN  = 3'd4;

	function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] a, input logic [XW-1:0] b);
		return AW'(a) * AW'(GRID_SIDE) + AW'(b);
	endfunction

	function automatic logic is_full(input logic [2:0] p, input logic [2:0] q,
		input logic [2:0] cap);
		return ({1'b0, p} + {1'b0, q}) >= {1'b0, cap};
	endfunction

	logic [3:0]      st_q;
	logic [AW-1:0]   clr_q;
	lppe_cmd_t       cmd_q;
	logic [XW-1:0]   x_q, y_q;
	logic [19:0]     rank_q;
	logic [AccW-1:0] acc_q;
	logic [2:0]      cp_q, cq_q;
	logic            isprey_q;
	logic [2:0]      nbp_q [4];
	logic [2:0]      nbq_q [4];
	logic [1:0]      k_q;
	logic [1:0]      opn_q;
	logic            opi_q;
	logic [XW-1:0]   opx_q [2];
	logic [XW-1:0]   opy_q [2];
	logic [5:0]      opv_q [2];
	logic [1:0]      opd_q [2];
	logic [3:0]      oc_q;
	logic [XW-1:0]   tx_q, ty_q;
	logic [1:0]      dpt_q, dqt_q;
	logic [18:0]     pt_q, qt_q;
	logic            rv_q;
	lppe_out_t       res_q;

	logic            site_we, row_we;
	logic [AW-1:0]   site_addr;
	logic [5:0]      site_wdata, site_rdata;
	logic [XW-1:0]   row_addr;
	logic [RsW-1:0]  row_wdata, row_rdata;

	logic [XW-1:0]   xr, xl, yu, yd;
	logic [XW-1:0]   nbx, nby;
	logic            slot_free;
	logic [19:0]     total;
	logic [19:0]     rank_in;
	logic [AccW-1:0] row_sum, col_s1, col_s2;

	assign xr = (x_q == XMax) ? '0 : x_q + XW'(1);
	assign xl = (x_q == '0) ? XMax : x_q - XW'(1);
	assign yu = (y_q == XMax) ? '0 : y_q + XW'(1);
	assign yd = (y_q == '0) ? XMax : y_q - XW'(1);

	always_comb begin
		unique case (k_q)
			2'd0: begin nbx = xr; nby = y_q; end
			2'd1: begin nbx = xl; nby = y_q; end
			2'd2: begin nbx = x_q; nby = yu; end
			default: begin nbx = x_q; nby = yd; end
		endcase
	end

	assign slot_free = !rv_q || !res_stall;
	assign total = {1'b0, pt_q} + {1'b0, qt_q};
	assign pop = (st_q == S_IDLE) && !q_empty;

	always_comb begin
		rank_in = {1'b0, q_data.rank};
		if (rank_in == '0) begin
			rank_in = 20'd1;
		end
		if (rank_in > total) begin
			rank_in = total;
		end
	end

	assign row_sum = acc_q + AccW'(row_rdata);
	assign col_s1 = acc_q + AccW'(site_rdata[5:3]);
	assign col_s2 = col_s1 + AccW'(site_rdata[2:0]);

	// memory ports
	always_comb begin
		site_we = 1'b0;
		site_wdata = opv_q[opi_q];
		site_addr = cell_addr(x_q, y_q);
		row_we = 1'b0;
		row_addr = x_q;
		row_wdata = row_rdata + {{(RsW-2){opd_q[opi_q][1]}}, opd_q[opi_q]};
		unique case (st_q)
			S_CLR: begin
				site_we = 1'b1;
				site_wdata = '0;
				site_addr = clr_q;
				row_we = (clr_q < AW'(GRID_SIDE));
				row_addr = clr_q[XW-1:0];
				row_wdata = '0;
			end
			S_NB_RD, S_NB_CK: begin
				site_addr = cell_addr(nbx, nby);
			end
			S_OP_RD: begin
				row_addr = opx_q[opi_q];
			end
			S_OP_WR: begin
				site_we = 1'b1;
				site_addr = cell_addr(opx_q[opi_q], opy_q[opi_q]);
				row_we = 1'b1;
				row_addr = opx_q[opi_q];
			end
			default: begin
			end
		endcase
	end

	lppe_ram #(.WIDTH(6), .DEPTH(Cells)) u_site_ram (
		.clk  (clk),
		.we   (site_we),
		.waddr(site_addr),
		.wdata(site_wdata),
		.raddr(site_addr),
		.rdata(site_rdata)
	);

	lppe_ram #(.WIDTH(RsW), .DEPTH(GRID_SIDE)) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_addr),
		.wdata(row_wdata),
		.raddr(row_addr),
		.rdata(row_rdata)
	);

	// event decision
	logic [2:0]    sp [5];
	logic [2:0]    sq [5];
	logic [2:0]    cand [5];
	logic [2:0]    ncand;
	logic          test_prey;
	logic [2:0]    mode;
	logic [2:0]    cnt, run, pick;
	logic [18:0]   prod;
	logic          hit;
	logic [XW-1:0] dx, dy;
	logic [2:0]    dp, dq;
	logic [1:0]    d_n;
	logic [3:0]    d_oc;
	logic [XW-1:0] d_tx, d_ty;
	logic [1:0]    d_dpt, d_dqt;
	logic [XW-1:0] d_opx [2];
	logic [XW-1:0] d_opy [2];
	logic [5:0]    d_opv [2];
	logic [1:0]    d_opd [2];

	always_comb begin
		sp[0] = cp_q;
		sq[0] = cq_q;
		for (int i = 0; i < 4; i++) begin
			sp[i+1] = nbp_q[i];
			sq[i+1] = nbq_q[i];
		end

		if (!isprey_q) begin
			if (cmd_q.act < cfg.pred_move_threshold) begin
				mode = M_PMOVE;
			end else if (cmd_q.act < cfg.pred_eat_threshold) begin
				mode = M_EAT;
			end else begin
				mode = M_DIE;
			end
		end else if (cmd_q.act < cfg.prey_move_threshold) begin
			mode = M_YMOVE;
		end else begin
			mode = M_BIRTH;
		end

		cand[0] = SC_RIGHT; cand[1] = SC_LEFT; cand[2] = SC_UP; cand[3] = SC_DOWN;
		cand[4] = SC_OWN;
		ncand = 3'd4;
		test_prey = 1'b0;
		if (mode == M_EAT) begin
			cand[0] = SC_OWN; cand[1] = SC_UP; cand[2] = SC_DOWN;
			cand[3] = SC_RIGHT; cand[4] = SC_LEFT;
			ncand = 3'd5;
			test_prey = 1'b1;
		end else if (mode == M_BIRTH) begin
			ncand = 3'd5;
		end

		cnt = '0;
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < ncand && (test_prey ? (sq[cand[i]] != '0)
				: !is_full(sp[cand[i]], sq[cand[i]], cfg.max_occupancy))) begin
				cnt = cnt + 3'd1;
			end
		end
		prod = {3'b0, cmd_q.nroll} * {16'b0, cnt};

		run = '0;
		pick = SC_OWN;
		for (int i = 0; i < 5; i++) begin
			if (3'(i) < ncand && (test_prey ? (sq[cand[i]] != '0)
				: !is_full(sp[cand[i]], sq[cand[i]], cfg.max_occupancy))) begin
				if (run == prod[18:16]) begin
					pick = cand[i];
				end
				run = run + 3'd1;
			end
		end
		hit = (cnt != '0);

		unique case (pick)
			SC_RIGHT: begin dx = xr; dy = y_q; end
			SC_LEFT:  begin dx = xl; dy = y_q; end
			SC_UP:    begin dx = x_q; dy = yu; end
			SC_DOWN:  begin dx = x_q; dy = yd; end
			default:  begin dx = x_q; dy = y_q; end
		endcase
		dp = sp[pick];
		dq = sq[pick];

		d_n = 2'd0;
		d_tx = x_q;
		d_ty = y_q;
		d_dpt = 2'd0;
		d_dqt = 2'd0;
		d_opx[0] = x_q; d_opy[0] = y_q; d_opv[0] = {cp_q, cq_q}; d_opd[0] = 2'd0;
		d_opx[1] = dx;  d_opy[1] = dy;  d_opv[1] = {dp, dq};     d_opd[1] = 2'd0;
		unique case (mode)
			M_PMOVE: begin
				d_oc = hit ? OC_PRED_MOVED : OC_PRED_BLOCKED;
				if (hit) begin
					d_n = 2'd2;
					d_tx = dx; d_ty = dy;
					d_opv[0] = {cp_q - 3'd1, cq_q}; d_opd[0] = 2'b11;
					d_opv[1] = {dp + 3'd1, dq};     d_opd[1] = 2'b01;
				end
			end
			M_EAT: begin
				d_oc = hit ? OC_ATE : OC_NO_PREY;
				if (hit) begin
					d_n = 2'd1;
					d_tx = dx; d_ty = dy;
					d_opx[0] = dx; d_opy[0] = dy;
					d_opv[0] = {dp + 3'd1, dq - 3'd1};
					d_dpt = 2'b01; d_dqt = 2'b11;
				end
			end
			M_DIE: begin
				d_oc = OC_DIED;
				d_n = 2'd1;
				d_opv[0] = {cp_q - 3'd1, cq_q}; d_opd[0] = 2'b11;
				d_dpt = 2'b11;
			end
			M_YMOVE: begin
				d_oc = hit ? OC_PREY_MOVED : OC_PREY_BLOCKED;
				if (hit) begin
					d_n = 2'd2;
					d_tx = dx; d_ty = dy;
					d_opv[0] = {cp_q, cq_q - 3'd1}; d_opd[0] = 2'b11;
					d_opv[1] = {dp, dq + 3'd1};     d_opd[1] = 2'b01;
				end
			end
			default: begin
				d_oc = hit ? OC_BORN : OC_BIRTH_BLOCKED;
				if (hit) begin
					d_n = 2'd1;
					d_tx = dx; d_ty = dy;
					d_opx[0] = dx; d_opy[0] = dy;
					d_opv[0] = {dp, dq + 3'd1}; d_opd[0] = 2'b01;
					d_dqt = 2'b01;
				end
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLR;
			clr_q <= '0;
			rv_q  <= 1'b0;
			pt_q  <= '0;
			qt_q  <= '0;
		end else begin
			if (rv_q && !res_stall && st_q != S_FIN) begin
				rv_q <= 1'b0;
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CellLast) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						if (q_data.command == CMD_PLACE) begin
							st_q <= S_PL_RD;
						end else if (total == '0) begin
							st_q <= S_FIN;
						end else begin
							st_q <= S_ROW_RD;
						end
					end
				end
				S_PL_RD:  st_q <= S_PL_CK;
				S_PL_CK: begin
					if (is_full(site_rdata[5:3], site_rdata[2:0], cfg.max_occupancy)) begin
						st_q <= S_FIN;
					end else begin
						st_q <= S_OP_RD;
					end
				end
				S_ROW_RD: st_q <= S_ROW_CK;
				S_ROW_CK: begin
					if (row_sum >= AccW'(rank_q)) begin
						st_q <= S_COL_RD;
					end else if (x_q == XMax) begin
						st_q <= S_FIN;
					end else begin
						st_q <= S_ROW_RD;
					end
				end
				S_COL_RD: st_q <= S_COL_CK;
				S_COL_CK: begin
					if (col_s2 >= AccW'(rank_q)) begin
						st_q <= S_NB_RD;
					end else if (y_q == XMax) begin
						st_q <= S_FIN;
					end else begin
						st_q <= S_COL_RD;
					end
				end
				S_NB_RD:  st_q <= S_NB_CK;
				S_NB_CK: begin
					st_q <= (k_q == 2'd3) ? S_DEC : S_NB_RD;
				end
				S_DEC: begin
					st_q <= (d_n == 2'd0) ? S_FIN : S_OP_RD;
				end
				S_OP_RD:  st_q <= S_OP_WR;
				S_OP_WR: begin
					if ({1'b0, opi_q} == opn_q - 2'd1) begin
						st_q <= S_FIN;
					end else begin
						st_q <= S_OP_RD;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						rv_q <= 1'b1;
						pt_q <= pt_q + {{17{dpt_q[1]}}, dpt_q};
						qt_q <= qt_q + {{17{dqt_q[1]}}, dqt_q};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				cmd_q  <= q_data;
				x_q    <= (q_data.command == CMD_EVENT) ? '0 : XW'(q_data.x);
				y_q    <= (q_data.command == CMD_EVENT) ? '0 : XW'(q_data.y);
				rank_q <= rank_in;
				acc_q  <= '0;
				k_q    <= '0;
				opi_q  <= 1'b0;
				dpt_q  <= '0;
				dqt_q  <= '0;
				oc_q   <= OC_EMPTY;
				tx_q   <= '0;
				ty_q   <= '0;
			end
			S_PL_CK: begin
				tx_q <= x_q;
				ty_q <= y_q;
				opn_q <= 2'd1;
				opx_q[0] <= x_q;
				opy_q[0] <= y_q;
				opd_q[0] <= 2'b01;
				if (is_full(site_rdata[5:3], site_rdata[2:0], cfg.max_occupancy)) begin
					oc_q <= OC_PLACE_FULL;
				end else begin
					oc_q <= OC_PLACED;
					if (cmd_q.species == SPC_PREDATOR) begin
						opv_q[0] <= {site_rdata[5:3] + 3'd1, site_rdata[2:0]};
						dpt_q <= 2'b01;
					end else begin
						opv_q[0] <= {site_rdata[5:3], site_rdata[2:0] + 3'd1};
						dqt_q <= 2'b01;
					end
				end
			end
			S_ROW_CK: begin
				if (row_sum < AccW'(rank_q)) begin
					acc_q <= row_sum;
					x_q <= x_q + XW'(1);
				end
			end
			S_COL_CK: begin
				cp_q <= site_rdata[5:3];
				cq_q <= site_rdata[2:0];
				isprey_q <= (col_s1 < AccW'(rank_q));
				if (col_s2 < AccW'(rank_q)) begin
					acc_q <= col_s2;
					y_q <= y_q + XW'(1);
				end
			end
			S_NB_CK: begin
				nbp_q[k_q] <= site_rdata[5:3];
				nbq_q[k_q] <= site_rdata[2:0];
				k_q <= k_q + 2'd1;
			end
			S_DEC: begin
				opn_q <= d_n;
				oc_q  <= d_oc;
				tx_q  <= d_tx;
				ty_q  <= d_ty;
				dpt_q <= d_dpt;
				dqt_q <= d_dqt;
				for (int i = 0; i < 2; i++) begin
					opx_q[i] <= d_opx[i];
					opy_q[i] <= d_opy[i];
					opv_q[i] <= d_opv[i];
					opd_q[i] <= d_opd[i];
				end
			end
			S_OP_WR: begin
				opi_q <= 1'b1;
			end
			S_FIN: begin
				if (slot_free) begin
					res_q.outcome <= oc_q;
					res_q.target_row <= 8'(tx_q);
					res_q.target_column <= 8'(ty_q);
					res_q.predator_population <= pt_q + {{17{dpt_q[1]}}, dpt_q};
					res_q.prey_population <= qt_q + {{17{dqt_q[1]}}, dqt_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = rv_q;
	assign res = res_q;

endmodule
